[rtl/dgd_pkg.sv]
// Shared types and constants for the detection grid decoder.
// No dependencies; every other file of the block but dgd_if imports this package.
`timescale 1ns / 1ps
`default_nettype none
package dgd_pkg;

  localparam int GRID_STRIDE     = 16;
  localparam int MAX_CLASSES_DEF = 256;
  localparam int GRID_MAX        = 256;
  localparam int QUEUE_DEPTH     = 2;

  // configuration register indexes
  localparam logic [1:0] REG_NET_WIDTH  = 2'd0;
  localparam logic [1:0] REG_NET_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;
  localparam logic [1:0] REG_NUM_CLASS  = 2'd3;

  localparam logic [12:0] NET_WIDTH_RST  = 13'd352;
  localparam logic [12:0] NET_HEIGHT_RST = 13'd352;
  localparam logic [15:0] THRESHOLD_RST  = 16'd32768;
  localparam logic [8:0]  NUM_CLASS_RST  = 9'd80;

  // one finished cell handed from the front to the back
  typedef struct packed {
    logic [15:0]        best;
    logic [7:0]         label;
    logic [15:0]        obj;
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic signed [15:0] w_raw;
    logic signed [15:0] h_raw;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [8:0]         gx;
    logic [8:0]         gy;
  } cell_t;

endpackage
`default_nettype wire

[rtl/dgd_if.sv]
// Valid/ready channel interfaces for the detection grid decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface dgd_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        class_score;
  logic [15:0]        objectness;
  logic signed [15:0] x_raw;
  logic signed [15:0] y_raw;
  logic signed [15:0] w_raw;
  logic signed [15:0] h_raw;
  modport source (output valid, class_score, objectness, x_raw, y_raw, w_raw, h_raw,
                  input ready);
  modport sink (input valid, class_score, objectness, x_raw, y_raw, w_raw, h_raw,
                output ready);
endinterface

interface dgd_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] x_min;
  logic signed [19:0] y_min;
  logic signed [19:0] x_max;
  logic signed [19:0] y_max;
  logic [7:0]         label;
  logic [15:0]        score;
  modport source (output valid, x_min, y_min, x_max, y_max, label, score, input ready);
  modport sink (input valid, x_min, y_min, x_max, y_max, label, score, output ready);
endinterface
`default_nettype wire

[rtl/dgd_front.sv]
// Front end: running argmax over class items and cell position counters.
// Depends on dgd_pkg and dgd_if.
`timescale 1ns / 1ps
`default_nettype none
module dgd_front #(
  parameter int MAX_CLASSES = dgd_pkg::MAX_CLASSES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  dgd_in_if.sink             in_chan,
  input  wire logic [12:0]   net_width,
  input  wire logic [12:0]   net_height,
  input  wire logic [8:0]    num_classes,
  input  wire logic          push_ready,
  output logic               push,
  output dgd_pkg::cell_t     push_data
);
  import dgd_pkg::*;

  localparam logic [8:0] MAX_N = 9'(MAX_CLASSES);

  logic [15:0] best_score;
  logic [7:0]  best_class;
  logic [7:0]  class_counter;
  logic [7:0]  cell_column;
  logic [7:0]  cell_row;

  logic [8:0]  n_eff;
  logic        is_last;
  logic        accept;
  logic [15:0] cur_best;
  logic [7:0]  cur_cls;
  logic [8:0]  gx;
  logic [8:0]  gy;
  logic [8:0]  gx_raw;
  logic [8:0]  gy_raw;
  logic [8:0]  col_inc;
  logic [8:0]  row_inc;

  always_comb begin
    if (num_classes == 9'd0) n_eff = 9'd1;
    else if (num_classes > MAX_N) n_eff = MAX_N;
    else n_eff = num_classes;
  end

  assign gx_raw = net_width[12:4];
  assign gy_raw = net_height[12:4];
  assign gx = (gx_raw == 9'd0) ? 9'd1 : (gx_raw > 9'(GRID_MAX)) ? 9'(GRID_MAX) : gx_raw;
  assign gy = (gy_raw == 9'd0) ? 9'd1 : (gy_raw > 9'(GRID_MAX)) ? 9'(GRID_MAX) : gy_raw;

  assign is_last = ({1'b0, class_counter} + 9'd1) >= n_eff;
  // stall only an item that closes a cell while the queue is full
  assign in_chan.ready = push_ready || !is_last;
  assign accept = in_chan.valid && in_chan.ready;
  assign push = accept && is_last;

  always_comb begin
    cur_best = (class_counter == 8'd0) ? 16'd0 : best_score;
    cur_cls  = (class_counter == 8'd0) ? 8'd0 : best_class;
    if (in_chan.class_score > cur_best) begin
      cur_best = in_chan.class_score;
      cur_cls  = class_counter;
    end
  end

  assign col_inc = {1'b0, cell_column} + 9'd1;
  assign row_inc = {1'b0, cell_row} + 9'd1;

  always_comb begin
    push_data.best  = cur_best;
    push_data.label = cur_cls;
    push_data.obj   = in_chan.objectness;
    push_data.x_raw = in_chan.x_raw;
    push_data.y_raw = in_chan.y_raw;
    push_data.w_raw = in_chan.w_raw;
    push_data.h_raw = in_chan.h_raw;
    push_data.col   = cell_column;
    push_data.row   = cell_row;
    push_data.gx    = gx;
    push_data.gy    = gy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score    <= '0;
      best_class    <= '0;
      class_counter <= '0;
      cell_column   <= '0;
      cell_row      <= '0;
    end else if (accept) begin
      best_score <= cur_best;
      best_class <= cur_cls;
      if (!is_last) begin
        class_counter <= class_counter + 8'd1;
      end else begin
        class_counter <= '0;
        if (col_inc >= gx) begin
          cell_column <= '0;
          cell_row    <= (row_inc >= gy) ? 8'd0 : row_inc[7:0];
        end else begin
          cell_column <= col_inc[7:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/dgd_queue.sv]
// Short register queue of finished cells between front and back.
// Depends on dgd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dgd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  dgd_pkg::cell_t     push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output logic               pop_valid,
  output dgd_pkg::cell_t     pop_data
);
  import dgd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cell_t           slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != CW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule
`default_nettype wire

[rtl/dgd_back.sv]
// Back end: combined score by bitwise fifth root, box decode, output register.
// Depends on dgd_pkg and dgd_if.
`timescale 1ns / 1ps
`default_nettype none
module dgd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  input  dgd_pkg::cell_t     pop_data,
  output logic               pop,
  input  wire logic [15:0]   score_threshold,
  dgd_out_if.source          out_chan
);
  import dgd_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_P1   = 12'b000000000010,
    ST_P2   = 12'b000000000100,
    ST_P3   = 12'b000000001000,
    ST_P4   = 12'b000000010000,
    ST_S1   = 12'b000000100000,
    ST_S2   = 12'b000001000000,
    ST_S3   = 12'b000010000000,
    ST_B1   = 12'b000100000000,
    ST_B2   = 12'b001000000000,
    ST_B3   = 12'b010000000000,
    ST_DONE = 12'b100000000000
  } state_t;

  // piecewise-linear sigmoid, Q6.12 in, Q1.16 out in [0, 65536]
  function automatic logic [16:0] sigmoid_q(input logic signed [17:0] x);
    logic [17:0] u;
    logic [17:0] y;
    u = x[17] ? 18'(-x) : 18'(x);
    if (u >= 18'd20480) y = 18'd65536;
    else if (u >= 18'd9728) y = {1'b0, u[17:1]} + 18'd55296;
    else if (u >= 18'd4096) y = {u[16:0], 1'b0} + 18'd40960;
    else y = {u[15:0], 2'b00} + 18'd32768;
    if (x[17]) y = 18'd65536 - y;
    return y[16:0];
  endfunction

  function automatic logic signed [18:0] tanh_q(input logic signed [15:0] x);
    logic [16:0] s;
    s = sigmoid_q({x[15], x, 1'b0});
    return $signed({1'b0, s, 1'b0}) - 19'sd65536;
  endfunction

  function automatic logic signed [19:0] edge_q(input logic signed [29:0] v);
    logic signed [29:0] sh;
    sh = v >>> 9;
    if (sh > 30'sd524287) return 20'sd524287;
    if (sh < -30'sd524288) return -20'sd524288;
    return sh[19:0];
  endfunction

  state_t      state;
  cell_t       job;
  logic [79:0] p;
  logic [15:0] r;
  logic [3:0]  bit_idx;
  logic [31:0] sq;
  logic [63:0] q4;
  logic signed [18:0] tx;
  logic signed [18:0] ty;
  logic [16:0] sw;
  logic [16:0] sh;
  logic [25:0] bwx;
  logic [25:0] bwy;
  logic signed [29:0] cx;
  logic signed [29:0] cy;
  logic signed [19:0] e_x0;
  logic signed [19:0] e_y0;
  logic signed [19:0] e_x1;
  logic signed [19:0] e_y1;
  logic        out_valid;

  logic [31:0] m32;
  logic [47:0] m48;
  logic [63:0] m64;
  logic [79:0] m80;
  logic [15:0] c;
  logic [31:0] sq_n;
  logic [63:0] q4_n;
  logic [79:0] q5;
  logic        emit;
  logic        load_out;

  assign m32  = job.best * job.best;
  assign m48  = p[31:0] * job.obj;
  assign m64  = p[47:0] * job.obj;
  assign m80  = p[63:0] * job.obj;
  assign c    = r | (16'd1 << bit_idx);
  assign sq_n = c * c;
  assign q4_n = sq * sq;
  assign q5   = q4 * c;

  assign pop      = (state == ST_IDLE) && pop_valid;
  assign emit     = (job.obj >= score_threshold) && (r >= score_threshold);
  assign load_out = (state == ST_DONE) && emit && (!out_valid || out_chan.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_chan.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (pop_valid) state <= ST_P1;
        ST_P1:   state <= ST_P2;
        ST_P2:   state <= ST_P3;
        ST_P3:   state <= ST_P4;
        ST_P4:   state <= ST_S1;
        ST_S1:   state <= ST_S2;
        ST_S2:   state <= ST_S3;
        ST_S3:   state <= (bit_idx == 4'd0) ? ST_B1 : ST_S1;
        ST_B1:   state <= ST_B2;
        ST_B2:   state <= ST_B3;
        ST_B3:   state <= ST_DONE;
        ST_DONE: if (!emit || load_out) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        job     <= pop_data;
        r       <= '0;
        bit_idx <= 4'd15;
      end
      ST_P1: p <= {48'd0, m32};
      ST_P2: p <= {32'd0, m48};
      ST_P3: p <= {16'd0, m64};
      ST_P4: p <= m80;
      ST_S1: sq <= sq_n;
      ST_S2: q4 <= q4_n;
      ST_S3: begin
        if (q5 <= p) r <= c;
        bit_idx <= bit_idx - 4'd1;
      end
      ST_B1: begin
        tx <= tanh_q(job.x_raw);
        ty <= tanh_q(job.y_raw);
        sw <= sigmoid_q({{2{job.w_raw[15]}}, job.w_raw});
        sh <= sigmoid_q({{2{job.h_raw[15]}}, job.h_raw});
      end
      ST_B2: begin
        bwx <= sw * job.gx;
        bwy <= sh * job.gy;
        cx  <= $signed({5'd0, job.col, 17'd0}) + ($signed({{11{tx[18]}}, tx}) <<< 1);
        cy  <= $signed({5'd0, job.row, 17'd0}) + ($signed({{11{ty[18]}}, ty}) <<< 1);
      end
      ST_B3: begin
        e_x0 <= edge_q(cx - $signed({4'd0, bwx}));
        e_x1 <= edge_q(cx + $signed({4'd0, bwx}));
        e_y0 <= edge_q(cy - $signed({4'd0, bwy}));
        e_y1 <= edge_q(cy + $signed({4'd0, bwy}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_chan.x_min <= e_x0;
      out_chan.y_min <= e_y0;
      out_chan.x_max <= e_x1;
      out_chan.y_max <= e_y1;
      out_chan.label <= job.label;
      out_chan.score <= r;
    end
  end

  assign out_chan.valid = out_valid;

  a_start_from_queue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_P1) |-> $past(state == ST_IDLE && pop_valid))
    else $error("root sequencer started without a queued cell");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE && emit))
    else $error("result raised outside the done step");

  a_root_loop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_S3 && bit_idx != 4'd0) |=> (state == ST_S1))
    else $error("root loop left early");

endmodule
`default_nettype wire

[rtl/detection_grid_decode.sv]
// Top level of the detection grid decoder: configuration registers, front, queue, back.
// Depends on dgd_pkg, dgd_if, dgd_front, dgd_queue and dgd_back.
//
// Class score items stream in at one per cycle unless an item that closes a cell
// meets a full queue; the front keeps the running argmax (first maximum wins) and
// the cell column and row, and hands each finished cell to a two-entry queue. The
// back turns a cell into a box: four multiplies build m^2*o^3, a bitwise fifth-root
// search runs states S1, S2 and S3 for each of sixteen result bits, and three steps
// decode the box edges before the output register. Items that do not close a cell
// are never stalled; an item that closes a cell waits while the queue is full, so
// with few classes per cell the root loop sets the sustained rate. Configuration is
// written through a plain write port while the block is idle; the user is bound to this, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module detection_grid_decode #(
  parameter int MAX_CLASSES = dgd_pkg::MAX_CLASSES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  dgd_in_if.sink           in_chan,
  dgd_out_if.source        out_chan
);
  import dgd_pkg::*;

  logic [12:0] net_width;
  logic [12:0] net_height;
  logic [15:0] score_threshold;
  logic [8:0]  num_classes;

  logic  push;
  logic  push_ready;
  cell_t push_data;
  logic  pop;
  logic  pop_valid;
  cell_t pop_data;

  // hold register values; write one per request
  always_ff @(posedge clk) begin
    if (rst) begin
      net_width       <= NET_WIDTH_RST;
      net_height      <= NET_HEIGHT_RST;
      score_threshold <= THRESHOLD_RST;
      num_classes     <= NUM_CLASS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NET_WIDTH:  net_width       <= cfg_data[12:0];
        REG_NET_HEIGHT: net_height      <= cfg_data[12:0];
        REG_THRESHOLD:  score_threshold <= cfg_data;
        REG_NUM_CLASS:  num_classes     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // accept class items, push finished cells
  dgd_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_chan    (in_chan),
    .net_width  (net_width),
    .net_height (net_height),
    .num_classes(num_classes),
    .push_ready (push_ready),
    .push       (push),
    .push_data  (push_data)
  );

  // decouple the front from the slow root sequencer
  dgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  // score, threshold and box decode; drop cells below threshold
  dgd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_data       (pop_data),
    .pop            (pop),
    .score_threshold(score_threshold),
    .out_chan       (out_chan)
  );

endmodule
`default_nettype wire

[bench/dgd_checker.sv]
// Checker for the detection grid decoder: watches the config port and both channels,
// predicts every box and compares it. Depends on dgd_pkg and dgd_if.
`timescale 1ns / 1ps
module dgd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dgd_in_if           in_mon,
  dgd_out_if          out_mon,
  output int          fail_count,
  output int          pending
);
  import dgd_pkg::*;

  typedef struct packed {
    logic signed [19:0] x_min;
    logic signed [19:0] y_min;
    logic signed [19:0] x_max;
    logic signed [19:0] y_max;
    logic [7:0]         label;
    logic [15:0]        score;
  } box_t;

  box_t boxes_due[$];

  logic [12:0] net_w, net_h;
  logic [15:0] thresh;
  logic [8:0]  class_num;
  logic [15:0] run_best;
  logic [7:0]  run_label, class_cnt, col, row;

  function automatic logic [15:0] fifth_root(logic [15:0] m, logic [15:0] o);
    logic [79:0] p, q;
    logic [15:0] r, c;
    p = 80'(m);
    p = p * m; p = p * o; p = p * o; p = p * o;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      c = r | (16'd1 << b);
      q = 80'(c);
      q = q * c; q = q * c; q = q * c; q = q * c;
      if (q <= p) r = c;
    end
    return r;
  endfunction

  function automatic longint sig_q16(longint x);
    longint u, y;
    u = x < 0 ? -x : x;
    if (u >= 20480) y = 65536;
    else if (u >= 9728) y = u / 2 + 55296;
    else if (u >= 4096) y = 2 * u + 40960;
    else y = 4 * u + 32768;
    return x < 0 ? 65536 - y : y;
  endfunction

  function automatic longint tanh_q16(longint x);
    return 2 * sig_q16(2 * x) - 65536;
  endfunction

  function automatic int grid_cells(logic [12:0] r);
    int g;
    g = r / GRID_STRIDE;
    if (g < 1) g = 1;
    if (g > GRID_MAX) g = GRID_MAX;
    return g;
  endfunction

  // floor to pixels (arithmetic shift floors), then saturate to 20 bits
  function automatic logic signed [19:0] edge_px(longint v);
    longint f;
    f = v >>> 16;
    if (f > 524287) f = 524287;
    if (f < -524288) f = -524288;
    return f[19:0];
  endfunction

  task automatic report(string what, box_t e, box_t a);
    fail_count++;
    if (fail_count <= 10)
      $display("MISMATCH %s: exp %0d %0d %0d %0d L%0d S%0d got %0d %0d %0d %0d L%0d S%0d",
               what, e.x_min, e.y_min, e.x_max, e.y_max, e.label, e.score,
               a.x_min, a.y_min, a.x_max, a.y_max, a.label, a.score);
  endtask

  always @(posedge clk) begin
    int n, gx, gy;
    logic [15:0] cb, sc;
    logic [7:0]  cl;
    longint tx, ty, sw, sh, ax, ay, bx, by;
    box_t bx_e, bx_a;
    if (rst) begin
      net_w <= NET_WIDTH_RST; net_h <= NET_HEIGHT_RST;
      thresh <= THRESHOLD_RST; class_num <= NUM_CLASS_RST;
      run_best <= '0; run_label <= '0; class_cnt <= '0; col <= '0; row <= '0;
      boxes_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NET_WIDTH:  net_w <= cfg_data[12:0];
          REG_NET_HEIGHT: net_h <= cfg_data[12:0];
          REG_THRESHOLD:  thresh <= cfg_data;
          REG_NUM_CLASS:  class_num <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        bx_a = '{out_mon.x_min, out_mon.y_min, out_mon.x_max, out_mon.y_max,
                 out_mon.label, out_mon.score};
        if (boxes_due.size() == 0) report("unexpected box", '0, bx_a);
        else begin
          bx_e = boxes_due.pop_front();
          if (bx_e !== bx_a) report("box", bx_e, bx_a);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        n = class_num == 0 ? 1 : (class_num > MAX_CLASSES_DEF ? MAX_CLASSES_DEF : class_num);
        cb = class_cnt == 0 ? 16'd0 : run_best;
        cl = class_cnt == 0 ? 8'd0 : run_label;
        if (in_mon.class_score > cb) begin
          cb = in_mon.class_score;
          cl = class_cnt;
        end
        run_best <= cb;
        run_label <= cl;
        if (int'(class_cnt) + 1 < n) class_cnt <= class_cnt + 8'd1;
        else begin
          // close the cell: decode the box from this item's raw values
          class_cnt <= '0;
          gx = grid_cells(net_w);
          gy = grid_cells(net_h);
          sc = fifth_root(cb, in_mon.objectness);
          tx = tanh_q16(longint'(in_mon.x_raw));
          ty = tanh_q16(longint'(in_mon.y_raw));
          sw = sig_q16(longint'(in_mon.w_raw));
          sh = sig_q16(longint'(in_mon.h_raw));
          ax = (longint'(col) * 65536 + tx) * 256;
          ay = (longint'(row) * 65536 + ty) * 256;
          bx = sw * longint'(gx * GRID_STRIDE) * 8;
          by = sh * longint'(gy * GRID_STRIDE) * 8;
          if (int'(col) + 1 >= gx) begin
            col <= '0;
            row <= (int'(row) + 1 >= gy) ? 8'd0 : row + 8'd1;
          end else col <= col + 8'd1;
          if (in_mon.objectness >= thresh && sc >= thresh)
            boxes_due.insert(boxes_due.size(),
                             '{edge_px(ax - bx), edge_px(ay - by), edge_px(ax + bx),
                               edge_px(ay + by), cl, sc});
        end
      end
    end
  end

  always @(posedge clk) pending <= rst ? 0 : boxes_due.size();
endmodule

[bench/tb_detection_grid_decode.sv]
// Testbench top for the detection grid decoder: clock, reset, config phases,
// class score stimulus and output back-pressure. Depends on dgd_pkg, dgd_if, dgd_checker.
`timescale 1ns / 1ps
module tb_detection_grid_decode;
  import dgd_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, pending;
  logic        quiet;       // no idling on either side
  logic        stall_req;   // ask the receiver for one long hold-off
  int          hold_left;
  logic        stall_done;

  dgd_in_if  in_chan();
  dgd_out_if out_chan();

  detection_grid_decode i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_chan(in_chan), .out_chan(out_chan)
  );

  dgd_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mon(in_chan), .out_mon(out_chan), .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // Receiver: drop ready with about 8 percent chance, except in quiet stretches; once, on
  // request, hold off so the two-entry queue fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
      hold_left <= 0;
      stall_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      hold_left <= 500;
      stall_done <= 1'b1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  // Offer one request and hold it until the block takes it. Ready is read at the
  // falling edge, where it is stable, and the request moves at the next rising edge.
  task automatic push_item(logic [15:0] cls, logic [15:0] obj, logic [15:0] xr,
                           logic [15:0] yr, logic [15:0] wr, logic [15:0] hr);
    logic took;
    if (!quiet && $urandom_range(99) < 8) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.class_score <= cls;
    in_chan.objectness <= obj;
    in_chan.x_raw <= xr; in_chan.y_raw <= yr;
    in_chan.w_raw <= wr; in_chan.h_raw <= hr;
    do begin
      @(negedge clk);
      took = in_chan.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Drain: drop valid, wait for every predicted box, then let the back end finish
  // any cell that produced no box before touching the registers.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_cfg(logic [12:0] w, logic [12:0] h, logic [15:0] thr, logic [8:0] n);
    cfg_we <= 1'b1;
    cfg_index <= REG_NET_WIDTH;  cfg_data <= 16'(w);   @(posedge clk);
    cfg_index <= REG_NET_HEIGHT; cfg_data <= 16'(h);   @(posedge clk);
    cfg_index <= REG_THRESHOLD;  cfg_data <= thr;      @(posedge clk);
    cfg_index <= REG_NUM_CLASS;  cfg_data <= 16'(n);   @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Raw logit: half the time the interesting range around the curve knees, else any value.
  function automatic logic [15:0] pick_raw();
    int v;
    if ($urandom_range(1)) return 16'($urandom);
    v = $urandom_range(49152) - 24576;
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_score();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(3) * 20000);  // ties: first maximum wins
      default: return 16'($urandom);
    endcase
  endfunction

  // Run well-formed cells with random content; a few noise items change the box
  // values mid-cell, and the phase may stop mid-cell to leave a broken sequence.
  task automatic run_cells(int items, int n_eff);
    logic [15:0] obj, xr, yr, wr, hr;
    int k;
    k = 0;
    while (k < items) begin
      obj = ($urandom_range(9) < 7) ? 16'($urandom_range(65535, 30000)) : 16'($urandom);
      xr = pick_raw(); yr = pick_raw(); wr = pick_raw(); hr = pick_raw();
      for (int c = 0; c < n_eff && k < items; c++) begin
        if ($urandom_range(19) == 0) begin
          xr = pick_raw(); hr = pick_raw();
        end
        push_item(pick_score(), obj, xr, yr, wr, hr);
        k++;
      end
    end
  endtask

  typedef struct {
    logic [12:0] w, h;
    logic [15:0] thr;
    logic [8:0]  n;
    int          n_eff, items;
  } phase_t;

  phase_t phases[$];

  task automatic add_phase(logic [12:0] w, logic [12:0] h, logic [15:0] thr,
                           logic [8:0] n, int n_eff, int items);
    phase_t ph;
    ph.w = w; ph.h = h; ph.thr = thr; ph.n = n; ph.n_eff = n_eff; ph.items = items;
    phases.insert(phases.size(), ph);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0; cfg_index <= REG_NET_WIDTH; cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.class_score <= '0; in_chan.objectness <= '0;
    in_chan.x_raw <= '0; in_chan.y_raw <= '0; in_chan.w_raw <= '0; in_chan.h_raw <= '0;
    quiet <= 1'b0;
    stall_req <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one class per cell, threshold zero so every cell yields a box.
    write_cfg(13'd352, 13'd352, 16'd0, 9'd1);
    push_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);          // no class above zero
    push_item(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_item(16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_item(16'd1, 16'hFFFF, 16'd4096, -16'sd4096, 16'd9728, -16'sd9728);
    push_item(16'hFFFF, 16'd1, 16'd4095, -16'sd4095, 16'd9727, -16'sd9727);
    push_item(16'd30000, 16'd50000, 16'd20480, -16'sd20480, 16'd20479, -16'sd20479);
    push_item(16'd12345, 16'd54321, 16'd2048, -16'sd2048, 16'd0, 16'd1);
    push_item(16'hFFFF, 16'd0, 16'd10240, 16'd4864, -16'sd2432, 16'd12000);
    push_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    push_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    drain();
    // Top threshold: only a perfect cell passes.
    write_cfg(13'd16, 13'd16, 16'hFFFF, 9'd1);
    push_item(16'hFFFF, 16'hFFFF, 16'd100, -16'sd100, 16'd0, 16'd0);
    push_item(16'hFFFE, 16'hFFFF, 16'd100, -16'sd100, 16'd0, 16'd0);
    drain();

    add_phase(13'd352, 13'd352, 16'd32768, 9'd80, 80, 240);
    add_phase(13'd16, 13'd16, 16'd0, 9'd1, 1, 60);       // long hold-off here
    add_phase(13'd4096, 13'd4096, 16'd65535, 9'd2, 2, 60);
    add_phase(13'd0, 13'd8191, 16'd1000, 9'd0, 1, 60);
    add_phase(13'd8191, 13'd0, 16'd20000, 9'd300, 256, 300);
    add_phase(13'd64, 13'd48, 16'd30000, 9'd3, 3, 100);
    add_phase(13'd160, 13'd96, 16'd0, 9'd1, 1, 80);     // quiet stretch
    add_phase(13'd64, 13'd64, 16'd10000, 9'd5, 5, 103); // stops mid-cell
    add_phase(13'd33, 13'd100, 16'd40000, 9'd2, 2, 100); // counter past count
    add_phase(13'd4095, 13'd31, 16'd25000, 9'd7, 7, 150);
    add_phase(13'd48, 13'd32, 16'd0, 9'd256, 256, 60);

    foreach (phases[i]) begin
      write_cfg(phases[i].w, phases[i].h, phases[i].thr, phases[i].n);
      quiet <= (i == 6);
      stall_req <= (i == 1);
      run_cells(phases[i].items, phases[i].n_eff);
      drain();
    end
    quiet <= 1'b0;

    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
